// ===== rtl/path_normalizer_macros.svh =====
// ----------------------------------------------------------------------------
// path_normalizer_macros.svh
// Assertion macros shared by the path normalizer RTL. With SYNTH defined the
// macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef PATH_NORMALIZER_MACROS_SVH
`define PATH_NORMALIZER_MACROS_SVH

`ifndef SYNTH

// A property that must hold at every clock edge outside reset.
`define PN_CHECK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that must be followed by another in the next.
`define PN_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PN_CHECK(name, prop, msg)
`define PN_CHECK_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== rtl/pn_pkg.sv =====
// ----------------------------------------------------------------------------
// pn_pkg
// Types, codes and constants shared by the path normalizer modules.
// ----------------------------------------------------------------------------
package pn_pkg;

    // Default capacity of the output byte store.
    localparam int PN_PATH_BYTES = 256;

    // The component start stack holds this many entries.
    localparam int STACK_DEPTH = 128;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = STACK_AW + 1;

    // The byte store is split into this many interleaved lanes.
    localparam int LANES  = 4;
    localparam int LANE_W = $clog2(LANES);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_FINISH = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    // Where the tokenizer stands within the path.
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_COMP  = 2'd1,
        PH_NAME  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_in;
        logic [7:0] read_index;
    } req_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_length;
        logic [7:0] out_byte;
    } rsp_item_t;

    // One write burst into the byte store: an optional separator, up to two
    // held dots, then one character.
    typedef struct packed {
        logic       go;
        logic       slash;
        logic [1:0] dots;
        logic [7:0] ch;
    } put_req_t;

    // Operations on the component start stack.
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stack_cmd_t;

    // Number of bytes a write burst carries.
    function automatic logic [2:0] put_count(put_req_t req);
        put_count = {2'b00, req.slash} + {1'b0, req.dots} + 3'd1;
    endfunction

endpackage

// ===== rtl/pn_byte_store.sv =====
// ----------------------------------------------------------------------------
// pn_byte_store
// Output byte store in four interleaved lanes, so a burst of up to four
// consecutive bytes is written at once. Reads are registered.
// ----------------------------------------------------------------------------
module pn_byte_store #(
    parameter int PATH_BYTES = pn_pkg::PN_PATH_BYTES,
    parameter int LEN_W      = $clog2(PATH_BYTES)
) (
    input  logic             clk,
    input  pn_pkg::put_req_t put,
    input  logic [LEN_W-1:0] put_base,
    input  logic             rd_en,
    input  logic [7:0]       rd_index,
    output logic [7:0]       rd_byte
);
    import pn_pkg::*;

    localparam int BANK_DEPTH = (PATH_BYTES + LANES - 1) / LANES;
    localparam int BA_W       = $clog2(BANK_DEPTH);
    localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(PATH_BYTES - 1);

    logic [LANES-1:0]             wr_en;
    logic [LANES-1:0][BA_W-1:0]   wr_addr;
    logic [LANES-1:0][7:0]        wr_data;
    logic [LANES-1:0][LANE_W-1:0] lane_off;
    logic [LANES-1:0][LEN_W:0]    lane_pos;
    logic [LANES-1:0][7:0]        bank_q;
    logic [2:0]                   count;
    logic [2:0]                   dot_end;
    logic [LANE_W-1:0]            lane_reg;
    logic [BA_W-1:0]              rd_addr;

    // Each lane takes the burst byte whose address falls on it. Bytes past
    // the last usable position are dropped.
    always_comb
    begin
        count   = put_count(put);
        dot_end = {2'b00, put.slash} + {1'b0, put.dots};
        for (int b = 0; b < LANES; b++)
        begin
            lane_off[b] = LANE_W'(b) - put_base[LANE_W-1:0];
            lane_pos[b] = (LEN_W + 1)'(put_base) + (LEN_W + 1)'(lane_off[b]);
            wr_en[b]    = put.go && ({1'b0, lane_off[b]} < count) && (lane_pos[b] < MAX_LEN);
            wr_addr[b]  = BA_W'(lane_pos[b] >> LANE_W);
            if ({1'b0, lane_off[b]} < {2'b00, put.slash})
            begin
                wr_data[b] = CH_SLASH;
            end
            else if ({1'b0, lane_off[b]} < dot_end)
            begin
                wr_data[b] = CH_DOT;
            end
            else
            begin
                wr_data[b] = put.ch;
            end
        end
    end

    assign rd_addr = BA_W'(rd_index >> LANE_W);

    for (genvar b = 0; b < LANES; b++)
    begin : g_bank
        logic [7:0] store_mem [BANK_DEPTH];
        logic [7:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en[b])
            begin
                store_mem[wr_addr[b]] <= wr_data[b];
            end
            if (rd_en)
            begin
                q_reg <= store_mem[rd_addr];
            end
        end

        assign bank_q[b] = q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            lane_reg <= rd_index[LANE_W-1:0];
        end
    end

    assign rd_byte = bank_q[lane_reg];

endmodule

// ===== rtl/pn_comp_stack.sv =====
// ----------------------------------------------------------------------------
// pn_comp_stack
// Stack of component start positions. The top entry is held in a register
// and the entry below it is prefetched from memory, so a pop takes its new
// top straight from the prefetch register.
// ----------------------------------------------------------------------------
module pn_comp_stack #(
    parameter int W = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pn_pkg::stack_cmd_t         cmd,
    input  logic [W-1:0]               push_data,
    output logic [pn_pkg::DEPTH_W-1:0] depth,
    output logic [W-1:0]               top
);
    import pn_pkg::*;

    logic [W-1:0]       stack_mem [STACK_DEPTH];
    logic [W-1:0]       below_reg;
    logic [W-1:0]       top_reg;
    logic [W-1:0]       top_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_base;
    logic [DEPTH_W-1:0] depth_next;
    logic [DEPTH_W-1:0] rd_ptr;

    always_comb
    begin
        depth_base = cmd.clear ? '0 : depth_reg;
        depth_next = depth_base;
        top_next   = top_reg;
        if (cmd.push)
        begin
            depth_next = depth_base + DEPTH_W'(1);
            top_next   = push_data;
        end
        else if (cmd.pop)
        begin
            depth_next = depth_base - DEPTH_W'(1);
            top_next   = below_reg;
        end
        // Prefetch the entry that becomes the top after the next pop.
        rd_ptr = depth_next - DEPTH_W'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[depth_base[STACK_AW-1:0]] <= push_data;
        end
        below_reg <= stack_mem[rd_ptr[STACK_AW-1:0]];
        top_reg   <= top_next;
    end

    assign depth = depth_reg;
    assign top   = top_reg;

endmodule

// ===== rtl/path_normalizer.sv =====
`include "path_normalizer_macros.svh"
// ----------------------------------------------------------------------------
// path_normalizer
// Streaming Unix path canonicalizer with a readable output byte store.
// ----------------------------------------------------------------------------
// The block takes one request item per clock, unless its response stalls,
// and returns one response item for each in the cycle after acceptance; a
// new item is taken in the same cycle that the previous response leaves.
// Append items feed the path a character at a time: a leading slash makes it
// absolute, slash runs collapse, "." components vanish and ".." drops the
// last kept component together with its separator. A finish item closes the
// path and reports its length, with an empty result turned into "/". Read
// items return one byte of the normalized path, and may be issued while the
// path is still being built. At most PATH_BYTES-1 bytes are kept; further
// bytes are dropped and the overflow status is raised until the next path
// starts. The rate of one item per cycle comes from two memories: the byte
// store is split into four lanes so that a component start (separator, held
// dots and a character) is written as one burst, and the component start
// stack keeps its top entry in a register with the next one prefetched, so
// ".." costs one stack access. Both memories need no clearing after reset;
// a path start rewrites whatever it later reads back.
// ----------------------------------------------------------------------------
module path_normalizer #(
    parameter int PATH_BYTES = pn_pkg::PN_PATH_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  pn_pkg::req_item_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output pn_pkg::rsp_item_t rsp
);
    import pn_pkg::*;

    localparam int LEN_W = $clog2(PATH_BYTES);
    localparam int CMP_W = (LEN_W > 8) ? LEN_W : 8;
    localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(PATH_BYTES - 1);

    // Tokenizer state.
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [1:0]         dots_reg;
    logic [1:0]         dots_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic               ovf_reg;
    logic               ovf_next;

    // Response register.
    logic               rsp_valid_reg;
    status_t            status_reg;
    status_t            status_next;
    logic [7:0]         length_reg;
    logic               rd_ok_reg;

    logic               accept;
    logic               fresh;
    phase_t             phase_eff;
    logic [LEN_W-1:0]   len0;
    logic [LEN_W-1:0]   len_after;
    logic [1:0]         dots0;
    logic               ovf0;
    logic [DEPTH_W-1:0] depth0;
    logic               is_slash;
    logic               is_dot;
    logic               rd_hit;
    logic               rd_en;
    logic [LEN_W:0]     put_end;

    put_req_t           put;
    logic [LEN_W-1:0]   put_base;
    stack_cmd_t         scmd;
    logic [DEPTH_W-1:0] stk_depth;
    logic [LEN_W-1:0]   stk_top;
    logic [7:0]         rd_byte;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // The first append or finish item after a finish (or after reset) opens a new
    // path: the length, stack, held dots and overflow flag are taken as cleared.
    assign fresh     = (phase_reg == PH_START);
    assign phase_eff = fresh ? PH_COMP : phase_reg;
    assign len0      = fresh ? '0 : len_reg;
    assign dots0     = fresh ? 2'd0 : dots_reg;
    assign ovf0      = fresh ? 1'b0 : ovf_reg;
    assign depth0    = fresh ? '0 : stk_depth;

    assign is_slash  = (req.char_in == CH_SLASH);
    assign is_dot    = (req.char_in == CH_DOT);
    assign rd_hit    = CMP_W'(req.read_index) < CMP_W'(len_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        dots_next   = dots_reg;
        len_after   = len_reg;
        ovf_next    = ovf_reg;
        status_next = ST_OK;
        rd_en       = 1'b0;
        scmd        = '0;
        put         = '0;
        put.ch      = req.char_in;
        put_base    = len0;

        if (accept)
        begin
            unique case (opcode_t'(req.opcode))
                OP_APPEND:
                begin
                    scmd.clear = fresh;
                    len_after  = len0;
                    ovf_next   = ovf0;
                    dots_next  = 2'd0;
                    phase_next = PH_COMP;
                    if (fresh && is_slash)
                    begin
                        // Leading slash of an absolute path.
                        put.go = 1'b1;
                    end
                    else if (is_slash)
                    begin
                        // End of a component: ".." pops the last kept one.
                        if (phase_eff == PH_COMP && dots0 == 2'd2 && depth0 != '0)
                        begin
                            scmd.pop  = 1'b1;
                            len_after = stk_top;
                        end
                    end
                    else if (phase_eff == PH_COMP && is_dot && dots0 != 2'd2)
                    begin
                        // Dots are held until the component proves to be a name.
                        dots_next = dots0 + 2'd1;
                    end
                    else if (phase_eff == PH_COMP)
                    begin
                        // A regular name begins: record where it starts, then
                        // write the separator, the held dots and this character.
                        scmd.push  = (depth0 < DEPTH_W'(STACK_DEPTH));
                        ovf_next   = ovf0 || !scmd.push;
                        put.go     = 1'b1;
                        put.slash  = (depth0 != '0);
                        put.dots   = dots0;
                        phase_next = PH_NAME;
                    end
                    else
                    begin
                        put.go     = 1'b1;
                        phase_next = PH_NAME;
                    end
                end
                OP_FINISH:
                begin
                    scmd.clear = fresh;
                    ovf_next   = ovf0;
                    dots_next  = 2'd0;
                    phase_next = PH_START;
                    len_after  = len0;
                    if (phase_eff == PH_COMP && dots0 == 2'd2 && depth0 != '0)
                    begin
                        scmd.pop  = 1'b1;
                        len_after = stk_top;
                    end
                    // An empty result becomes the root.
                    if (len_after == '0)
                    begin
                        put.go   = 1'b1;
                        put.ch   = CH_SLASH;
                        put_base = '0;
                    end
                end
                OP_READ:
                begin
                    rd_en = rd_hit;
                end
                OP_NONE:
                begin
                end
            endcase
        end

        // Bytes past the last usable position are dropped and flagged.
        put_end  = (LEN_W + 1)'(put_base) + (LEN_W + 1)'(put_count(put));
        len_next = len_after;
        if (put.go)
        begin
            if (put_end > MAX_LEN)
            begin
                len_next = MAX_LEN[LEN_W-1:0];
                ovf_next = 1'b1;
            end
            else
            begin
                len_next = put_end[LEN_W-1:0];
            end
        end

        if (accept)
        begin
            unique case (opcode_t'(req.opcode)) inside
                OP_APPEND, OP_FINISH: status_next = ovf_next ? ST_OVERFLOW : ST_OK;
                OP_READ:              status_next = rd_hit ? ST_OK : ST_RANGE;
                OP_NONE:              status_next = ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            dots_reg      <= 2'd0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            dots_reg  <= dots_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload; it holds while the response is stalled because no
    // item is accepted then.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            length_reg <= 8'(len_next);
            rd_ok_reg  <= rd_en;
        end
    end

    pn_byte_store #(
        .PATH_BYTES (PATH_BYTES),
        .LEN_W      (LEN_W)
    ) u_store (
        .clk      (clk),
        .put      (put),
        .put_base (put_base),
        .rd_en    (rd_en),
        .rd_index (req.read_index),
        .rd_byte  (rd_byte)
    );

    pn_comp_stack #(
        .W (LEN_W)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (scmd),
        .push_data (len0),
        .depth     (stk_depth),
        .top       (stk_top)
    );

    assign rsp_valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.out_length = length_reg;
    assign rsp.out_byte   = rd_ok_reg ? rd_byte : 8'd0;

    `PN_CHECK(a_len_cap, (LEN_W + 1)'(len_reg) <= MAX_LEN, "length beyond store capacity")
    `PN_CHECK(a_depth_cap, stk_depth <= DEPTH_W'(STACK_DEPTH), "stack depth beyond capacity")
    `PN_CHECK(a_dots_phase, (dots_reg == 2'd0) || (phase_reg == PH_COMP), "dots held mid-name")
    `PN_CHECK_NEXT(a_rsp_follows, accept, rsp_valid, "accepted item gave no response")
    `PN_CHECK_NEXT(a_read_keeps_len, accept && (req.opcode == OP_READ),
                   len_reg == $past(len_reg), "read changed the length")

endmodule
